// File: hdl/melody_tone_sequencer_top_macros.svh
// Assertion macros used by the checker file of the melody tone sequencer.
`ifndef MELODY_TONE_SEQUENCER_TOP_MACROS_SVH
`define MELODY_TONE_SEQUENCER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("melody tone sequencer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("melody tone sequencer assertion failed");

`endif

// File: hdl/mts_pkg.sv
package mts_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam longint unsigned CLOCK_HZ = 64'd125000000;
    localparam int PWM_DIVIDER = 128;

    localparam int FUNC_W = 3;
    localparam int SLOT_W = 8;
    localparam int TONE_W = 25;
    localparam int DUR_W = 16;
    localparam int IDX_W = 9;
    localparam int WRAP_W = 16;
    localparam int DUTY_W = 15;
    localparam int ENTRY_W = TONE_W + DUR_W;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [WRAP_W-1:0] WRAP_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 3'd0,
        FUNC_LOAD   = 3'd1,
        FUNC_START  = 3'd2,
        FUNC_STOP   = 3'd3,
        FUNC_SINGLE = 3'd4
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] note_slot;
        logic [TONE_W-1:0] tone_millihertz;
        logic [DUR_W-1:0]  duration_ms;
        logic              repeat_flag;
    } in_t;

    typedef struct packed {
        logic              tone_enable;
        logic [WRAP_W-1:0] wrap_count;
        logic [DUTY_W-1:0] duty_count;
        logic              busy_playing;
        logic [IDX_W-1:0]  position;
    } out_t;

endpackage

// File: hdl/melody_tone_sequencer_top.sv
// Melody tone sequencer: plays a table of notes as PWM square-wave settings.
// Input channel s_valid/s_ready/s_data carries one command transaction: a
// millisecond tick, a note load, start play, stop, or a single note.
// Result channel m_valid/m_ready/m_data returns exactly one transaction per
// command with the PWM settings and the playback status after the command.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the song length
// and is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. Commands are handled one at a time.
// Ticks that do not end a note, loads, stops, unused codes and silent single
// notes go straight to ST_DONE. A command that starts a sounding note passes
// a note table read (play only), a saturation check and, unless it saturates,
// a 16-step divider that forms the period count from the clock rate and the
// note frequency. The result sits in an output register; the next command is
// accepted while it waits; a finished result stalls in place until taken.
// Synchronous reset clears the playback state and the song length; the note
// table is undefined until its entries are loaded.
module melody_tone_sequencer_top import mts_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_data
);

    localparam logic [63:0] NUM64 = 64'(CLOCK_HZ) * 64'd1000;
    localparam int NUM_W = $clog2(NUM64 + 64'd1);
    localparam logic [NUM_W-1:0] CLK_MILLI = NUM_W'(NUM64);
    localparam int DEN_W = TONE_W + $clog2(PWM_DIVIDER + 1);
    localparam int DS_W = DEN_W + WRAP_W - 1;
    localparam int SAT_W = DEN_W + WRAP_W;
    localparam int CNT_W = $clog2(WRAP_W);
    localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(TABLE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ADV  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_SAT  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    song_length_reg, song_length_next;
    logic [IDX_W-1:0]    next_index_reg, next_index_next;
    logic [DUR_W-1:0]    time_left_reg, time_left_next;
    logic                playing_reg, playing_next;
    logic                loop_reg, loop_next;
    logic                single_reg, single_next;
    logic                output_on_reg, output_on_next;
    logic [WRAP_W-1:0]   period_reg, period_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [DS_W-1:0]     ds_reg, ds_next;
    logic [WRAP_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;

    logic [ENTRY_W-1:0]  note_table [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  wr_entry;

    logic [IDX_W-1:0]    len;
    logic [IDX_W-1:0]    idx;
    logic [TONE_W-1:0]   tone_sel;
    logic [TONE_W-1:0]   rd_tone;
    logic [DUR_W-1:0]    rd_dur;
    logic [WRAP_W-1:0]   quot_step;
    logic                step_ge;
    logic                slot_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign len      = (song_length_reg > DEPTH_IDX) ? DEPTH_IDX : song_length_reg;
    assign rd_tone  = rd_data_reg[TONE_W-1:0];
    assign rd_dur   = rd_data_reg[ENTRY_W-1:TONE_W];
    assign tone_sel = (state_reg == ST_IDLE) ? s_data.tone_millihertz : rd_tone;
    assign wr_entry = {s_data.duration_ms, s_data.tone_millihertz};
    assign slot_ok  = (32'(s_data.note_slot) < 32'(TABLE_DEPTH));
    assign step_ge  = ({{(DS_W - NUM_W){1'b0}}, rem_reg} >= ds_reg);
    assign quot_step = {quot_reg[WRAP_W-2:0], step_ge};

    always_comb begin
        state_next       = state_reg;
        song_length_next = song_length_reg;
        next_index_next  = next_index_reg;
        time_left_next   = time_left_reg;
        playing_next     = playing_reg;
        loop_next        = loop_reg;
        single_next      = single_reg;
        output_on_next   = output_on_reg;
        period_next      = period_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        ds_next          = ds_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        idx              = next_index_reg;
        rd_addr          = next_index_reg[ADDR_W-1:0];

        if (cfg_valid) begin
            song_length_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DONE;
                    unique case (s_data.func)
                        FUNC_TICK: begin
                            if (playing_reg) begin
                                if (time_left_reg <= DUR_W'(1)) begin
                                    state_next = ST_ADV;
                                end else begin
                                    time_left_next = time_left_reg - DUR_W'(1);
                                end
                            end else if (single_reg) begin
                                if (time_left_reg <= DUR_W'(1)) begin
                                    single_next    = 1'b0;
                                    output_on_next = 1'b0;
                                    time_left_next = '0;
                                end else begin
                                    time_left_next = time_left_reg - DUR_W'(1);
                                end
                            end
                        end
                        FUNC_LOAD: begin
                            mem_we = slot_ok;
                        end
                        FUNC_START: begin
                            single_next     = 1'b0;
                            loop_next       = s_data.repeat_flag;
                            next_index_next = '0;
                            playing_next    = 1'b1;
                            state_next      = ST_ADV;
                        end
                        FUNC_STOP: begin
                            playing_next    = 1'b0;
                            loop_next       = 1'b0;
                            single_next     = 1'b0;
                            next_index_next = '0;
                            time_left_next  = '0;
                            output_on_next  = 1'b0;
                        end
                        FUNC_SINGLE: begin
                            if (!playing_reg) begin
                                time_left_next = s_data.duration_ms;
                                single_next    = 1'b1;
                                if (s_data.tone_millihertz == '0) begin
                                    output_on_next = 1'b0;
                                end else begin
                                    den_next   = DEN_W'(tone_sel) * DEN_W'(PWM_DIVIDER);
                                    state_next = ST_SAT;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADV: begin
                if (next_index_reg >= len) begin
                    idx = '0;
                end
                if ((next_index_reg >= len) && !(loop_reg && (len != '0))) begin
                    output_on_next = 1'b0;
                    playing_next   = 1'b0;
                    time_left_next = '0;
                    state_next     = ST_DONE;
                end else begin
                    rd_addr         = idx[ADDR_W-1:0];
                    mem_re          = 1'b1;
                    next_index_next = idx + IDX_W'(1);
                    state_next      = ST_RD;
                end
            end
            ST_RD: begin
                time_left_next = rd_dur;
                if (rd_tone == '0) begin
                    output_on_next = 1'b0;
                    state_next     = ST_DONE;
                end else begin
                    den_next   = DEN_W'(tone_sel) * DEN_W'(PWM_DIVIDER);
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                if ({den_reg, {WRAP_W{1'b0}}} <= SAT_W'(CLK_MILLI)) begin
                    period_next    = WRAP_MAX;
                    output_on_next = 1'b1;
                    state_next     = ST_DONE;
                end else begin
                    rem_next   = CLK_MILLI;
                    ds_next    = {den_reg, {(WRAP_W - 1){1'b0}}};
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_ge) begin
                    rem_next = rem_reg - ds_reg[NUM_W-1:0];
                end
                ds_next   = ds_reg >> 1;
                quot_next = quot_step;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WRAP_W - 1)) begin
                    period_next    = quot_step;
                    output_on_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.tone_enable  = output_on_reg;
                    m_data_next.wrap_count   = output_on_reg ? period_reg : '0;
                    m_data_next.duty_count   = output_on_reg ? period_reg[WRAP_W-1:1] : '0;
                    m_data_next.busy_playing = playing_reg;
                    m_data_next.position     = next_index_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            note_table[s_data.note_slot[ADDR_W-1:0]] <= wr_entry;
        end
        if (mem_re) begin
            rd_data_reg <= note_table[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            song_length_reg <= '0;
            next_index_reg  <= '0;
            time_left_reg   <= '0;
            playing_reg     <= 1'b0;
            loop_reg        <= 1'b0;
            single_reg      <= 1'b0;
            output_on_reg   <= 1'b0;
            period_reg      <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            song_length_reg <= song_length_next;
            next_index_reg  <= next_index_next;
            time_left_reg   <= time_left_next;
            playing_reg     <= playing_next;
            loop_reg        <= loop_next;
            single_reg      <= single_next;
            output_on_reg   <= output_on_next;
            period_reg      <= period_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        ds_reg     <= ds_next;
        quot_reg   <= quot_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: hdl/mts_checker.sv
`include "melody_tone_sequencer_top_macros.svh"

module mts_checker import mts_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    `MTS_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `MTS_ASSERT_SAME(a_off_is_zero, aclk, aresetn, m_valid && !m_data.tone_enable, (m_data.wrap_count == '0) && (m_data.duty_count == '0))
    `MTS_ASSERT_SAME(a_duty_half, aclk, aresetn, m_valid, m_data.duty_count == m_data.wrap_count[WRAP_W-1:1])
    `MTS_ASSERT_SAME(a_position_range, aclk, aresetn, m_valid, m_data.position <= IDX_W'(TABLE_DEPTH))

endmodule

bind melody_tone_sequencer_top mts_checker u_mts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: sim/testbench.sv
module testbench;
    import mts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PERCENT = 21;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 30;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_t              s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_t             m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data = '0;

    melody_tone_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    in_t              pending_commands[$];
    out_t             predicted_status[$];
    logic [IDX_W-1:0] song_len_writes[$];

    logic [TONE_W-1:0] note_tone[TABLE_DEPTH];
    logic [DUR_W-1:0]  note_ticks[TABLE_DEPTH];
    logic [IDX_W-1:0]  play_pos;
    logic [DUR_W-1:0]  ticks_left;
    logic [WRAP_W-1:0] period_count;
    logic [IDX_W-1:0]  song_len;
    bit                playing;
    bit                looping;
    bit                single_on;
    bit                tone_on;

    bit                     calm = 1'b0;
    bit [TABLE_DEPTH-1:0]   loaded_slots = '0;
    int                     commands_queued = 0;
    int                     results_checked = 0;
    int                     mismatches = 0;
    int                     settings_applied = 0;
    int                     cycle_count = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [WRAP_W-1:0] period_for(logic [TONE_W-1:0] tone);
        longint unsigned den;
        longint unsigned q;
        den = 64'(tone) * 64'(PWM_DIVIDER);
        if (den == 0) begin
            return WRAP_MAX;
        end
        q = (CLOCK_HZ * 64'd1000) / den;
        return (q > 64'(WRAP_MAX)) ? WRAP_MAX : q[WRAP_W-1:0];
    endfunction

    function automatic void sound_tone(logic [TONE_W-1:0] tone);
        if (tone == 0) begin
            tone_on = 1'b0;
        end else begin
            period_count = period_for(tone);
            tone_on = 1'b1;
        end
    endfunction

    function automatic void next_note();
        int len;
        len = (song_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(song_len);
        if (!playing) begin
            tone_on = 1'b0;
            return;
        end
        if (play_pos >= len) begin
            if (looping && len > 0) begin
                play_pos = '0;
            end else begin
                tone_on = 1'b0;
                playing = 1'b0;
                ticks_left = '0;
                return;
            end
        end
        sound_tone(note_tone[play_pos[ADDR_W-1:0]]);
        ticks_left = note_ticks[play_pos[ADDR_W-1:0]];
        play_pos = play_pos + 1'b1;
    endfunction

    function automatic out_t predict_status(in_t c);
        out_t r;
        case (c.func)
            FUNC_TICK: begin
                if (playing) begin
                    if (ticks_left <= 1) begin
                        next_note();
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end else if (single_on) begin
                    if (ticks_left <= 1) begin
                        single_on = 1'b0;
                        tone_on = 1'b0;
                        ticks_left = '0;
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            FUNC_LOAD: begin
                note_tone[c.note_slot] = c.tone_millihertz;
                note_ticks[c.note_slot] = c.duration_ms;
            end
            FUNC_START: begin
                single_on = 1'b0;
                looping = c.repeat_flag;
                play_pos = '0;
                playing = 1'b1;
                next_note();
            end
            FUNC_STOP: begin
                playing = 1'b0;
                looping = 1'b0;
                single_on = 1'b0;
                play_pos = '0;
                ticks_left = '0;
                tone_on = 1'b0;
            end
            FUNC_SINGLE: begin
                if (!playing) begin
                    sound_tone(c.tone_millihertz);
                    ticks_left = c.duration_ms;
                    single_on = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.tone_enable = tone_on;
        r.wrap_count = tone_on ? period_count : '0;
        r.duty_count = tone_on ? period_count[WRAP_W-1:1] : '0;
        r.busy_playing = playing;
        r.position = play_pos;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            play_pos = '0;
            ticks_left = '0;
            period_count = '0;
            playing = 1'b0;
            looping = 1'b0;
            single_on = 1'b0;
            tone_on = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_status.push_back(predict_status(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_commands.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    s_data <= pending_commands.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
            song_len = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                song_len = cfg_data;
                settings_applied++;
            end
            if (!cfg_valid || cfg_ready) begin
                if (song_len_writes.size() != 0) begin
                    cfg_data <= song_len_writes.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_status.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = predicted_status.pop_front();
                    results_checked++;
                    check_field("tone_enable", want.tone_enable, m_data.tone_enable);
                    check_field("wrap_count", want.wrap_count, m_data.wrap_count);
                    check_field("duty_count", want.duty_count, m_data.duty_count);
                    check_field("busy_playing", want.busy_playing, m_data.busy_playing);
                    check_field("position", want.position, m_data.position);
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, predicted_status.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_cmd(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] slot,
                            logic [TONE_W-1:0] tone, logic [DUR_W-1:0] dur, logic rep);
        in_t c;
        c.func = f;
        c.note_slot = slot;
        c.tone_millihertz = tone;
        c.duration_ms = dur;
        c.repeat_flag = rep;
        if (f == FUNC_LOAD) begin
            loaded_slots[slot] = 1'b1;
        end
        pending_commands.push_back(c);
        commands_queued++;
    endtask

    function automatic logic [TONE_W-1:0] random_tone();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            return '0;
        end else if (pick < 40) begin
            return TONE_W'($urandom_range(1, 20000));
        end else if (pick < 75) begin
            return TONE_W'($urandom_range(20000, 2000000));
        end
        return TONE_W'($urandom);
    endfunction

    function automatic logic [DUR_W-1:0] random_ticks();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return DUR_W'($urandom_range(0, 3));
        end else if (pick < 90) begin
            return DUR_W'($urandom_range(4, 12));
        end else if (pick < 97) begin
            return DUR_W'($urandom);
        end
        return '1;
    endfunction

    task automatic push_random(logic [FUNC_W-1:0] f);
        push_cmd(f, SLOT_W'($urandom), random_tone(), random_ticks(), 1'($urandom));
    endtask

    task automatic push_ticks(int count);
        for (int i = 0; i < count; i++) begin
            push_cmd(FUNC_TICK, SLOT_W'($urandom), TONE_W'($urandom), DUR_W'($urandom),
                     1'($urandom));
        end
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_commands.size() != 0 || s_valid || predicted_status.size() != 0);
    endtask

    task automatic write_song_length(logic [IDX_W-1:0] len);
        song_len_writes.push_back(len);
        do @(negedge aclk);
        while (song_len_writes.size() != 0 || cfg_valid);
    endtask

    // Every slot a melody of this length can reach is loaded before any start.
    task automatic run_phase(logic [IDX_W-1:0] len, int count);
        int reach;
        int first;
        int pick;
        logic [SLOT_W-1:0] slot;
        write_song_length(len);
        reach = (len > TABLE_DEPTH) ? TABLE_DEPTH : int'(len);
        for (int i = 0; i < reach; i++) begin
            if (!loaded_slots[i]) begin
                push_cmd(FUNC_LOAD, SLOT_W'(i), random_tone(), random_ticks(), 1'($urandom));
            end
        end
        first = commands_queued;
        while (commands_queued - first < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 9) begin
                push_random(FUNC_START);
                push_ticks($urandom_range(2, 12));
            end else if (pick < 50) begin
                push_ticks($urandom_range(1, 6));
            end else if (pick < 64) begin
                slot = (reach > 0 && $urandom_range(0, 3) != 0) ?
                       SLOT_W'($urandom_range(0, reach - 1)) : SLOT_W'($urandom);
                push_cmd(FUNC_LOAD, slot, random_tone(), random_ticks(), 1'($urandom));
            end else if (pick < 76) begin
                push_random(FUNC_SINGLE);
                push_ticks($urandom_range(0, 4));
            end else if (pick < 81) begin
                push_random(FUNC_STOP);
            end else if (pick < 84) begin
                push_random(FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)));
            end else begin
                push_ticks(1);
            end
        end
        push_random(FUNC_STOP);
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Song length zero after reset: play stops at once, single notes and loads.
        push_cmd(FUNC_TICK, '1, '1, '1, 1'b1);
        push_cmd(FUNC_START, '0, '0, '0, 1'b1);
        push_cmd(FUNC_START, '0, '0, '0, 1'b0);
        push_cmd(FUNC_SINGLE, '0, '1, 16'd2, 1'b0);
        push_ticks(2);
        push_cmd(FUNC_SINGLE, '0, 25'd1, 16'd0, 1'b0);
        push_cmd(FUNC_SINGLE, '0, 25'd440000, 16'd3, 1'b0);
        push_cmd(FUNC_SINGLE, '0, '0, 16'd1, 1'b0);
        push_ticks(1);
        push_cmd(FUNC_LOAD, 8'd0, 25'd440000, 16'd2, 1'b0);
        push_cmd(FUNC_LOAD, 8'd1, '0, 16'd1, 1'b0);
        push_cmd(FUNC_LOAD, 8'd2, '1, 16'd0, 1'b0);
        push_cmd(FUNC_LOAD, '1, 25'd1, '1, 1'b1);
        for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) begin
            push_random(FUNC_W'(f));
        end
        push_cmd(FUNC_STOP, '0, '0, '0, 1'b0);
        drain();

        // A three note melody played once, then looped past its end and stopped.
        write_song_length(9'd3);
        push_cmd(FUNC_START, '0, '0, '0, 1'b0);
        push_cmd(FUNC_SINGLE, '0, 25'd880000, 16'd5, 1'b0);
        push_ticks(4);
        push_cmd(FUNC_START, '0, '0, '0, 1'b1);
        push_ticks(7);
        push_cmd(FUNC_STOP, '0, '0, '0, 1'b0);
        drain();

        run_phase(9'd1, 200);
        run_phase(9'd5, 220);
        calm = 1'b1;
        run_phase(9'd256, 260);
        calm = 1'b0;
        run_phase('1, 220);
        run_phase(9'd0, 120);
        run_phase(9'd3, 220);
        run_phase(IDX_W'($urandom_range(6, 40)), 220);
        run_phase(9'd2, 200);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d command transactions and checked %0d results", commands_queued,
                 results_checked);
        $display("across %0d song length settings; %0d mismatches.", settings_applied,
                 mismatches);
        if (mismatches == 0 && predicted_status.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/mts_pkg.sv
hdl/melody_tone_sequencer_top.sv
hdl/mts_checker.sv
sim/testbench.sv
